// ----- hw/rtl/i2c_register_word_master_core_assert.svh -----
// ----------------------------------------------------------------------------
// I2C register word master - assertion macros
// Clocked assertion forms shared by the checker.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_WORD_MASTER_CORE_ASSERT_SVH
`define I2C_REGISTER_WORD_MASTER_CORE_ASSERT_SVH

// Check a property at every rising edge outside reset.
`define I2CRW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("i2c register word master: check failed");

// Check that a condition implies a consequence in the next cycle.
`define I2CRW_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("i2c register word master: sequence check failed");

`endif

// ----- hw/rtl/i2crw_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C register word master - package
// Codes, field widths and item layouts shared by the core and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2crw_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned DevW     = 7;
  localparam int unsigned RegW     = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned RepW     = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  // Request kind carried in tuser
  typedef enum logic [OpW-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_REPORT = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Bus report codes
  localparam logic [RepW-1:0] REP_START     = 4'd0;
  localparam logic [RepW-1:0] REP_REP_START = 4'd1;
  localparam logic [RepW-1:0] REP_ADDR_ACK  = 4'd2;
  localparam logic [RepW-1:0] REP_DATA_ACK  = 4'd4;
  localparam logic [RepW-1:0] REP_RX_ACKED  = 4'd6;
  localparam logic [RepW-1:0] REP_RX_NACKED = 4'd7;

  // Bus command codes
  localparam logic [CmdW-1:0] CMD_NONE    = 3'd0;
  localparam logic [CmdW-1:0] CMD_START   = 3'd1;
  localparam logic [CmdW-1:0] CMD_REP     = 3'd2;
  localparam logic [CmdW-1:0] CMD_SEND    = 3'd3;
  localparam logic [CmdW-1:0] CMD_RX_ACK  = 3'd4;
  localparam logic [CmdW-1:0] CMD_RX_NACK = 3'd5;
  localparam logic [CmdW-1:0] CMD_STOP    = 3'd6;

  // Input item, lowest field last in the declaration
  typedef struct packed {
    logic [InDataW-44:0] pad;
    logic [ByteW-1:0]    rx_byte;
    logic [RepW-1:0]     bus_report;
    logic [WordW-1:0]    write_value;
    logic [RegW-1:0]     reg_index;
    logic [DevW-1:0]     device_address;
  } in_item_t;

  // Result item, lowest field last in the declaration
  typedef struct packed {
    logic [OutDataW-31:0] pad;
    logic                 busy_res;
    logic [WordW-1:0]     read_word;
    logic                 failed;
    logic                 done_res;
    logic [ByteW-1:0]     tx_byte;
    logic [CmdW-1:0]      command;
  } out_item_t;

endpackage

// ----- hw/rtl/i2c_register_word_master_core.sv -----
// ----------------------------------------------------------------------------
// I2C register word master core
// Transaction sequencer for 16-bit register reads and writes on an I2C bus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Feed requests and bus reports in as items; every item returns exactly one
// result item holding the next bus command. A write request runs start,
// address+W, register byte, high byte, low byte, stop; a read request runs
// start, address+W, register byte, repeated start, address+R, two receives
// (ack, then nack) and stop, and returns the word high byte first. Any
// unexpected report while busy answers with stop, done and failed. Requests
// arriving while busy and reports arriving while idle return command none.
// Throughput is one item per clock while the result side does not stall; an item
// passes through the input register and then the result register, with the
// sequencer state updated as it leaves the input register. The result register
// lets a new item enter while a finished result still waits on out_tready.
module i2c_register_word_master_core
  import i2crw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [6:0] device_address, [14:7] reg_index, [30:15] write_value,
  // [34:31] bus_report, [42:35] rx_byte, [47:43] zero
  input  logic [InDataW-1:0]  in_tdata,
  // [1:0] op
  input  logic [OpW-1:0]      in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [2:0] command, [10:3] tx_byte, [11] done_res, [12] failed,
  // [28:13] read_word, [29] busy_res, [31:30] zero
  output logic [OutDataW-1:0] out_tdata
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_SLAW  = 3'd2,
    PH_DATA  = 3'd3,
    PH_REP   = 3'd4,
    PH_SLAR  = 3'd5,
    PH_RX    = 3'd6
  } phase_t;

  // Input register
  logic       in_v_r;
  in_item_t   in_item_r;
  logic [OpW-1:0] in_op_r;

  // Result register
  logic       out_v_r;
  out_item_t  out_item_r;

  // Sequencer state
  phase_t           phase_r,   phase_nxt;
  logic             is_read_r, is_read_nxt;
  logic [DevW-1:0]  target_r,  target_nxt;
  logic [RegW-1:0]  regb_r,    regb_nxt;
  logic [WordW-1:0] pending_r, pending_nxt;
  logic [1:0]       count_r,   count_nxt;

  out_item_t res_nxt;
  logic      out_free;
  logic      advance;

  // Move the held item into the result register when that slot opens.
  assign out_free  = !out_v_r || out_tready;
  assign advance   = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_item_r;

  // Next state and result for the item in the input register.
  always_comb begin
    logic bad;
    bad         = 1'b0;
    phase_nxt   = phase_r;
    is_read_nxt = is_read_r;
    target_nxt  = target_r;
    regb_nxt    = regb_r;
    pending_nxt = pending_r;
    count_nxt   = count_r;
    res_nxt     = '0;
    res_nxt.command = CMD_NONE;

    if (phase_r == PH_IDLE) begin
      // Start a transaction on a read or write request; drop everything else.
      if (in_op_r == OP_READ || in_op_r == OP_WRITE) begin
        is_read_nxt     = (in_op_r == OP_READ);
        target_nxt      = in_item_r.device_address;
        regb_nxt        = in_item_r.reg_index;
        pending_nxt     = (in_op_r == OP_WRITE) ? in_item_r.write_value : '0;
        count_nxt       = 2'd0;
        res_nxt.command = CMD_START;
        phase_nxt       = PH_START;
      end
    end else if (in_op_r == OP_REPORT) begin
      unique case (phase_r)
        PH_START: begin
          if (in_item_r.bus_report == REP_START) begin
            res_nxt.command = CMD_SEND;
            res_nxt.tx_byte = {target_r, 1'b0};
            phase_nxt       = PH_SLAW;
          end else begin
            bad = 1'b1;
          end
        end
        PH_SLAW: begin
          if (in_item_r.bus_report == REP_ADDR_ACK) begin
            res_nxt.command = CMD_SEND;
            res_nxt.tx_byte = regb_r;
            count_nxt       = 2'd0;
            phase_nxt       = PH_DATA;
          end else begin
            bad = 1'b1;
          end
        end
        PH_DATA: begin
          if (in_item_r.bus_report != REP_DATA_ACK) begin
            bad = 1'b1;
          end else if (is_read_r) begin
            res_nxt.command = CMD_REP;
            phase_nxt       = PH_REP;
          end else if (count_r == 2'd0) begin
            res_nxt.command = CMD_SEND;
            res_nxt.tx_byte = pending_r[WordW-1 -: ByteW];
            count_nxt       = 2'd1;
          end else if (count_r == 2'd1) begin
            res_nxt.command = CMD_SEND;
            res_nxt.tx_byte = pending_r[ByteW-1:0];
            count_nxt       = 2'd2;
          end else begin
            res_nxt.command  = CMD_STOP;
            res_nxt.done_res = 1'b1;
            phase_nxt        = PH_IDLE;
          end
        end
        PH_REP: begin
          if (in_item_r.bus_report == REP_REP_START) begin
            res_nxt.command = CMD_SEND;
            res_nxt.tx_byte = {target_r, 1'b1};
            phase_nxt       = PH_SLAR;
          end else begin
            bad = 1'b1;
          end
        end
        PH_SLAR: begin
          if (in_item_r.bus_report == REP_ADDR_ACK) begin
            res_nxt.command = CMD_RX_ACK;
            count_nxt       = 2'd0;
            phase_nxt       = PH_RX;
          end else begin
            bad = 1'b1;
          end
        end
        PH_RX: begin
          if (count_r == 2'd0) begin
            // First byte is the high byte; ask for the last one with a nack.
            if (in_item_r.bus_report == REP_RX_ACKED) begin
              pending_nxt     = {in_item_r.rx_byte, {ByteW{1'b0}}};
              res_nxt.command = CMD_RX_NACK;
              count_nxt       = 2'd1;
            end else begin
              bad = 1'b1;
            end
          end else begin
            if (in_item_r.bus_report == REP_RX_NACKED) begin
              pending_nxt       = {pending_r[WordW-1 -: ByteW], in_item_r.rx_byte};
              res_nxt.read_word = {pending_r[WordW-1 -: ByteW], in_item_r.rx_byte};
              res_nxt.command   = CMD_STOP;
              res_nxt.done_res  = 1'b1;
              phase_nxt         = PH_IDLE;
            end else begin
              bad = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // Abort: stop the bus and report failure.
      if (bad) begin
        res_nxt           = '0;
        res_nxt.command   = CMD_STOP;
        res_nxt.done_res  = 1'b1;
        res_nxt.failed    = 1'b1;
        phase_nxt         = PH_IDLE;
      end
    end

    res_nxt.busy_res = (phase_nxt != PH_IDLE);
  end

  // Handshake flags, sequencer state and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      phase_r   <= PH_IDLE;
      is_read_r <= 1'b0;
      target_r  <= '0;
      regb_r    <= '0;
      pending_r <= '0;
      count_r   <= '0;
    end else begin
      // Hold the input register until the item moves on.
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (in_tvalid && in_tready) begin
        in_item_r <= in_tdata;
        in_op_r   <= in_tuser;
      end

      // Advance the sequencer as the item lands in the result register.
      if (advance) begin
        out_item_r <= res_nxt;
        phase_r    <= phase_nxt;
        is_read_r  <= is_read_nxt;
        target_r   <= target_nxt;
        regb_r     <= regb_nxt;
        pending_r  <= pending_nxt;
        count_r    <= count_nxt;
      end
      if (out_free) begin
        out_v_r <= in_v_r;
      end
    end
  end

endmodule

// ----- hw/rtl/i2crw_checker.sv -----
// ----------------------------------------------------------------------------
// I2C register word master - port checker
// Watches the result channel of the core and checks result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_register_word_master_core_assert.svh"

module i2crw_checker
  import i2crw_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  out_item_t res;
  assign res = out_tdata;

  // A stalled result stays put.
  `I2CRW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                     out_tvalid && $stable(out_tdata))
  // A failure always ends the transaction with stop and no word.
  `I2CRW_ASSERT(a_fail_stop, clk, rst_n, !out_tvalid || !res.failed ||
                (res.done_res && res.command == CMD_STOP && res.read_word == '0))
  // A finished transaction leaves the sequencer idle.
  `I2CRW_ASSERT(a_done_idle, clk, rst_n, !out_tvalid || !res.done_res || !res.busy_res)
  // Only stop finishes a transaction, and a byte goes out only with send.
  `I2CRW_ASSERT(a_cmd_fields, clk, rst_n, !out_tvalid ||
                ((res.done_res == (res.command == CMD_STOP)) &&
                 (res.command == CMD_SEND || res.tx_byte == '0)))

endmodule

bind i2c_register_word_master_core i2crw_checker u_i2crw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// I2C register word master - testbench
// Drives requests and bus reports into the core, predicts every bus command
// in step with the accepted items and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import i2crw_pkg::*;

  // Sequencer phases of the predictor
  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ADDR_W, S_DATA, S_REP, S_ADDR_R, S_RX
  } seq_phase_t;

  localparam logic [RepW-1:0] REP_OTHER = 4'd8;
  localparam logic [RepW-1:0] REP_HIGH  = 4'd15;

  // Clock, reset and ports; every input starts at a known value
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic [OpW-1:0]      in_tuser   = OP_NOP;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  // Predicted sequencer state
  seq_phase_t      seq_phase;
  logic            rd_mode;
  logic [DevW-1:0] tgt_addr;
  logic [RegW-1:0] reg_byte;
  logic [WordW-1:0] word_buf;
  logic [1:0]      byte_cnt;

  out_item_t cmd_expect_q[$];
  bit        no_idle = 1'b0;
  int        err_cnt = 0;
  int        n_items = 0;
  int        n_ignored = 0;
  int        n_ok = 0;
  int        n_abort = 0;

  i2c_register_word_master_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict the bus command that one accepted item causes; advance the state.
  function automatic out_item_t next_bus_command(op_t op, in_item_t d);
    out_item_t r;
    logic      abort;
    r = '0;
    abort = 1'b0;
    if (seq_phase == S_IDLE) begin
      // Only a request leaves idle; reports and no-ops are dropped
      if (op == OP_READ || op == OP_WRITE) begin
        rd_mode   = (op == OP_READ);
        tgt_addr  = d.device_address;
        reg_byte  = d.reg_index;
        word_buf  = (op == OP_WRITE) ? d.write_value : '0;
        byte_cnt  = '0;
        r.command = CMD_START;
        seq_phase = S_START;
      end
    end else if (op == OP_REPORT) begin
      case (seq_phase)
        S_START: begin
          if (d.bus_report == REP_START) begin
            r.command = CMD_SEND;
            r.tx_byte = {tgt_addr, 1'b0};
            seq_phase = S_ADDR_W;
          end else abort = 1'b1;
        end
        S_ADDR_W: begin
          if (d.bus_report == REP_ADDR_ACK) begin
            r.command = CMD_SEND;
            r.tx_byte = reg_byte;
            byte_cnt  = '0;
            seq_phase = S_DATA;
          end else abort = 1'b1;
        end
        S_DATA: begin
          if (d.bus_report != REP_DATA_ACK) begin
            abort = 1'b1;
          end else if (rd_mode) begin
            r.command = CMD_REP;
            seq_phase = S_REP;
          end else if (byte_cnt == 2'd0) begin
            r.command = CMD_SEND;
            r.tx_byte = word_buf[15:8];
            byte_cnt  = 2'd1;
          end else if (byte_cnt == 2'd1) begin
            r.command = CMD_SEND;
            r.tx_byte = word_buf[7:0];
            byte_cnt  = 2'd2;
          end else begin
            r.command  = CMD_STOP;
            r.done_res = 1'b1;
            seq_phase  = S_IDLE;
          end
        end
        S_REP: begin
          if (d.bus_report == REP_REP_START) begin
            r.command = CMD_SEND;
            r.tx_byte = {tgt_addr, 1'b1};
            seq_phase = S_ADDR_R;
          end else abort = 1'b1;
        end
        S_ADDR_R: begin
          if (d.bus_report == REP_ADDR_ACK) begin
            r.command = CMD_RX_ACK;
            byte_cnt  = '0;
            seq_phase = S_RX;
          end else abort = 1'b1;
        end
        S_RX: begin
          // First byte must come acked, the last one nacked
          if (byte_cnt == 2'd0) begin
            if (d.bus_report == REP_RX_ACKED) begin
              word_buf  = {d.rx_byte, 8'h00};
              r.command = CMD_RX_NACK;
              byte_cnt  = 2'd1;
            end else abort = 1'b1;
          end else begin
            if (d.bus_report == REP_RX_NACKED) begin
              word_buf    = {word_buf[15:8], d.rx_byte};
              r.read_word = word_buf;
              r.command   = CMD_STOP;
              r.done_res  = 1'b1;
              seq_phase   = S_IDLE;
            end else abort = 1'b1;
          end
        end
        default: seq_phase = S_IDLE;
      endcase
      if (abort) begin
        r           = '0;
        r.command   = CMD_STOP;
        r.done_res  = 1'b1;
        r.failed    = 1'b1;
        seq_phase   = S_IDLE;
      end
    end
    r.busy_res = (seq_phase != S_IDLE);
    if (r.command == CMD_NONE) n_ignored++;
    else if (r.failed) n_abort++;
    else if (r.done_res) n_ok++;
    return r;
  endfunction

  // Send one item after a random gap; record its prediction on acceptance.
  task automatic send_item(op_t op, in_item_t d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    cmd_expect_q.push_back(next_bus_command(op, d));
    n_items++;
  endtask

  // Request item; the report fields carry random don't-care content.
  task automatic send_req(op_t op, logic [DevW-1:0] dev, logic [RegW-1:0] rg,
                          logic [WordW-1:0] wv);
    in_item_t d;
    d                = '0;
    d.device_address = dev;
    d.reg_index      = rg;
    d.write_value    = wv;
    d.bus_report     = 4'($urandom_range(0, 15));
    d.rx_byte        = 8'($urandom);
    send_item(op, d);
  endtask

  // Bus report item; the request fields carry random don't-care content.
  task automatic send_report(logic [RepW-1:0] rep, logic [ByteW-1:0] rx);
    in_item_t d;
    d                = '0;
    d.device_address = 7'($urandom);
    d.reg_index      = 8'($urandom);
    d.write_value    = 16'($urandom);
    d.bus_report     = rep;
    d.rx_byte        = rx;
    send_item(OP_REPORT, d);
  endtask

  // Hold the input idle until every predicted result has come back.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic field_check(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      err_cnt++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t exp;
    if (cmd_expect_q.size() == 0) begin
      $error("result item with no prediction waiting: 0x%0h", got);
      err_cnt++;
    end else begin
      exp = cmd_expect_q.pop_front();
      field_check("command", 32'(exp.command), 32'(got.command));
      field_check("tx_byte", 32'(exp.tx_byte), 32'(got.tx_byte));
      field_check("done_res", 32'(exp.done_res), 32'(got.done_res));
      field_check("failed", 32'(exp.failed), 32'(got.failed));
      field_check("read_word", 32'(exp.read_word), 32'(got.read_word));
      field_check("busy_res", 32'(exp.busy_res), 32'(got.busy_res));
      field_check("pad", 32'(exp.pad), 32'(got.pad));
    end
  endtask

  // Result side: stall a random number of cycles per item, then take one.
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result(out_item_t'(out_tdata));
    end
  end

  // Reports while idle and no-ops are dropped without leaving idle.
  task automatic test_idle_ignores();
    send_report(REP_START, 8'h00);
    send_req(OP_NOP, 7'h7f, 8'hff, 16'hffff);
  endtask

  // Full write at the field maxima; a request and a no-op while busy drop out.
  task automatic test_write_word();
    send_req(OP_WRITE, 7'h7f, 8'hff, 16'hffff);
    send_req(OP_READ, 7'h00, 8'h00, 16'h0000);
    send_req(OP_NOP, 7'h00, 8'h00, 16'h0000);
    send_report(REP_START, 8'h00);
    send_report(REP_ADDR_ACK, 8'h00);
    send_report(REP_DATA_ACK, 8'h00);
    send_report(REP_DATA_ACK, 8'h00);
    send_report(REP_DATA_ACK, 8'h00);
  endtask

  // Full read at the field minima, high byte all ones and low byte zero.
  task automatic test_read_word();
    send_req(OP_READ, 7'h00, 8'h00, 16'h0000);
    send_report(REP_START, 8'h00);
    send_report(REP_ADDR_ACK, 8'h00);
    send_report(REP_DATA_ACK, 8'h00);
    send_report(REP_REP_START, 8'h00);
    send_report(REP_ADDR_ACK, 8'h00);
    send_report(REP_RX_ACKED, 8'hff);
    send_report(REP_RX_NACKED, 8'h00);
  endtask

  // An acked last byte is the wrong report and must abort the read.
  task automatic test_last_byte_acked();
    send_req(OP_READ, 7'h55, 8'ha5, 16'h0000);
    send_report(REP_START, 8'h00);
    send_report(REP_ADDR_ACK, 8'h00);
    send_report(REP_DATA_ACK, 8'h00);
    send_report(REP_REP_START, 8'h00);
    send_report(REP_ADDR_ACK, 8'h00);
    send_report(REP_RX_ACKED, 8'h12);
    send_report(REP_RX_ACKED, 8'h34);
  endtask

  // Reports outside the named codes abort at once.
  task automatic test_other_report();
    send_req(OP_WRITE, 7'h2a, 8'h5a, 16'h0000);
    send_report(REP_OTHER, 8'h00);
    send_req(OP_READ, 7'h01, 8'h80, 16'h8000);
    send_report(REP_HIGH, 8'hff);
  endtask

  // One transaction with random content; now and then a stray request
  // lands in the middle or a wrong report cuts it short.
  task automatic run_random_transaction();
    logic [RepW-1:0] steps[$];
    logic [RepW-1:0] bad;
    logic            rd;
    int              k;
    rd = 1'($urandom_range(0, 1));
    send_req(rd ? OP_READ : OP_WRITE, 7'($urandom), 8'($urandom), 16'($urandom));
    if (rd) steps = '{REP_START, REP_ADDR_ACK, REP_DATA_ACK, REP_REP_START,
                      REP_ADDR_ACK, REP_RX_ACKED, REP_RX_NACKED};
    else    steps = '{REP_START, REP_ADDR_ACK, REP_DATA_ACK, REP_DATA_ACK,
                      REP_DATA_ACK};
    for (k = 0; k < steps.size(); k++) begin
      if ($urandom_range(0, 24) == 0) begin
        case ($urandom_range(0, 2))
          0:       send_req(OP_READ, 7'($urandom), 8'($urandom), 16'($urandom));
          1:       send_req(OP_WRITE, 7'($urandom), 8'($urandom), 16'($urandom));
          default: send_req(OP_NOP, 7'($urandom), 8'($urandom), 16'($urandom));
        endcase
      end
      if ($urandom_range(0, 29) == 0) begin
        do bad = 4'($urandom_range(0, 15)); while (bad == steps[k]);
        send_report(bad, 8'($urandom));
        return;
      end
      send_report(steps[k], 8'($urandom));
    end
  endtask

  // Fully random item of any op with any report code.
  task automatic send_noise();
    in_item_t d;
    d                = '0;
    d.device_address = 7'($urandom);
    d.reg_index      = 8'($urandom);
    d.write_value    = 16'($urandom);
    d.bus_report     = 4'($urandom_range(0, 15));
    d.rx_byte        = 8'($urandom);
    send_item(op_t'($urandom_range(0, 3)), d);
  endtask

  task automatic test_random();
    while (n_items < 1550) begin
      // Toggle stretches with no idling on either side
      if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
      if ($urandom_range(0, 9) < 7) run_random_transaction();
      else send_noise();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    seq_phase = S_IDLE;
    rd_mode   = 1'b0;
    tgt_addr  = '0;
    reg_byte  = '0;
    word_buf  = '0;
    byte_cnt  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ignores();
    test_write_word();
    test_read_word();
    test_last_byte_acked();
    test_other_report();
    // Pause the sender until the directed results have all drained
    wait_all_results();
    test_random();

    wait_all_results();
    repeat (10) @(posedge clk);
    $display("covered %0d items: %0d words done, %0d aborts, %0d dropped items",
             n_items, n_ok, n_abort, n_ignored);
    $display("reads and writes with stray requests, wrong reports and idle gaps");
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/i2crw_pkg.sv
hw/rtl/i2c_register_word_master_core.sv
hw/rtl/i2crw_checker.sv
tb/tb_top.sv
